[rtl/core/tbp_pkg.sv]
// Package for the ten-bit to byte packer.
// Holds widths, request kind codes, register indexes and payload structs.
// No dependencies.
package tbp_pkg;

  localparam int ADDR_WIDTH      = 12;
  localparam int VALUE_WIDTH     = 10;
  localparam int BYTE_WIDTH      = 8;
  localparam int KIND_WIDTH      = 2;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_WIDTH-1:0] KIND_PACK     = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_FINALIZE = 2'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_RESTART  = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_END   = 1'd1;

  typedef struct packed {
    logic [KIND_WIDTH-1:0]  kind;
    logic [VALUE_WIDTH-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] write_address;
    logic [BYTE_WIDTH-1:0] write_byte;
    logic                  last;
  } out_item_t;

  // One or two byte writes produced by a single request.
  typedef struct packed {
    logic                  two;
    logic [ADDR_WIDTH-1:0] addr0;
    logic [BYTE_WIDTH-1:0] byte0;
    logic [ADDR_WIDTH-1:0] addr1;
    logic [BYTE_WIDTH-1:0] byte1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/core/tbp_front.sv]
// Front end of the packer: config registers, packing state and request decode.
// Turns each accepted request that yields writes into a write command. Depends on tbp_pkg.
module tbp_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tbp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [tbp_pkg::ADDR_WIDTH-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tbp_pkg::in_item_t                   in_data,
  input  logic                                q_full,
  output logic                                cmd_push,
  output tbp_pkg::cmd_t                       cmd
);

  localparam int AW = tbp_pkg::ADDR_WIDTH;
  localparam int BW = tbp_pkg::BYTE_WIDTH;

  logic [AW-1:0]   start_address;
  logic [AW-1:0]   end_address;
  logic [BW-1:0]   pending_byte, pending_byte_next;
  logic [2:0]      pending_count, pending_count_next;
  logic [AW-1:0]   current_address, current_address_next;
  logic            unwritten, unwritten_next;

  logic            accept;
  logic            produce;
  logic [2:0]      shift;
  logic [2*BW-1:0] word;
  logic [AW-1:0]   addr_inc, addr_inc2;
  logic [3:0]      count_inc;
  logic            may_now, may_after;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cmd_push = accept && produce;

  always_comb begin
    shift     = 3'd6 - pending_count;
    word      = {pending_byte, {BW{1'b0}}} | ((2*BW)'(in_data.value) << shift);
    addr_inc  = current_address + 1'b1;
    addr_inc2 = addr_inc + 1'b1;
    count_inc = {1'b0, pending_count} + 4'd2;
    may_now   = (pending_count == 3'd6 && current_address == end_address) ||
                (current_address < end_address);
    may_after = (count_inc == 4'd6 && addr_inc == end_address) ||
                (addr_inc < end_address);

    pending_byte_next    = pending_byte;
    pending_count_next   = pending_count;
    current_address_next = current_address;
    unwritten_next       = unwritten;
    produce              = 1'b0;
    cmd.two              = 1'b0;
    cmd.addr0            = current_address;
    cmd.byte0            = word[2*BW-1:BW];
    cmd.addr1            = addr_inc;
    cmd.byte1            = word[BW-1:0];

    unique case (in_data.kind)
      tbp_pkg::KIND_PACK: begin
        if (may_now) begin
          produce = 1'b1;
          if (count_inc[3] || !may_after) begin
            cmd.two              = 1'b1;
            current_address_next = addr_inc2;
            pending_byte_next    = '0;
            pending_count_next   = 3'd0;
            unwritten_next       = 1'b0;
          end else begin
            current_address_next = addr_inc;
            pending_byte_next    = word[BW-1:0];
            pending_count_next   = count_inc[2:0];
            unwritten_next       = 1'b1;
          end
        end
      end
      tbp_pkg::KIND_FINALIZE: begin
        if (unwritten && pending_count != 3'd0) begin
          produce        = 1'b1;
          cmd.byte0      = pending_byte;
          unwritten_next = 1'b0;
        end
      end
      tbp_pkg::KIND_RESTART: begin
        current_address_next = start_address;
        pending_byte_next    = '0;
        pending_count_next   = 3'd0;
        unwritten_next       = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0;
      end_address   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbp_pkg::REG_START: start_address <= cfg_data;
        tbp_pkg::REG_END:   end_address   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_byte    <= '0;
      pending_count   <= 3'd0;
      current_address <= '0;
      unwritten       <= 1'b0;
    end else if (accept) begin
      pending_byte    <= pending_byte_next;
      pending_count   <= pending_count_next;
      current_address <= current_address_next;
      unwritten       <= unwritten_next;
    end
  end

endmodule

[rtl/core/tbp_queue.sv]
// Short command queue between the packer front end and the write back end.
// Depends on tbp_pkg.
module tbp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tbp_pkg::cmd_t     push_data,
  input  logic              pop,
  output tbp_pkg::cmd_t     head,
  output tbp_pkg::q_stat_t  stat
);

  localparam int DEPTH = tbp_pkg::QUEUE_DEPTH;
  localparam int PW    = tbp_pkg::QUEUE_PTR_WIDTH;
  localparam int CW    = tbp_pkg::QUEUE_CNT_WIDTH;

  tbp_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/tbp_back.sv]
// Back end of the packer: splits queued commands into byte writes
// and holds them in the output register. Depends on tbp_pkg.
module tbp_back (
  input  logic               clk,
  input  logic               rst,
  input  tbp_pkg::cmd_t      head,
  input  tbp_pkg::q_stat_t   stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tbp_pkg::out_item_t out_data
);

  logic               out_free;
  logic               sec_valid;
  tbp_pkg::out_item_t sec_data;

  assign out_free = !out_valid || out_ready;
  assign pop      = out_free && !sec_valid && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else if (out_free) begin
      if (sec_valid) begin
        out_valid <= 1'b1;
        sec_valid <= 1'b0;
      end else if (!stat.empty) begin
        out_valid <= 1'b1;
        sec_valid <= head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (sec_valid) begin
        out_data <= sec_data;
      end else if (!stat.empty) begin
        out_data.write_address <= head.addr0;
        out_data.write_byte    <= head.byte0;
        out_data.last          <= !head.two;
        sec_data.write_address <= head.addr1;
        sec_data.write_byte    <= head.byte1;
        sec_data.last          <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/ten_bit_to_byte_packer_unit.sv]
// Top level of the ten-bit to byte packer.
// Instantiates tbp_front, tbp_queue and tbp_back; depends on tbp_pkg.
//
// Packs 10-bit values MSB first into bytes of the region set by start_address
// and end_address and issues byte writes. A request is taken in any cycle in
// which the two-entry command queue has room, so requests may arrive back to
// back. A pack request yields one write, two when a byte group completes or
// the region fills, or none once the region has no room; finalize yields at
// most one; restart and kind 3 yield none. The single output register issues
// one write per cycle while out_ready allows, so two-write requests fill the
// queue and stall input. Writes pass the queue, then the output register.
module ten_bit_to_byte_packer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tbp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [tbp_pkg::ADDR_WIDTH-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tbp_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tbp_pkg::out_item_t                  out_data
);

  logic             push, pop;
  tbp_pkg::cmd_t    push_data, head;
  tbp_pkg::q_stat_t stat;

  tbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (stat.full),
    .cmd_push  (push),
    .cmd       (push_data)
  );

  tbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  tbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (stat.full && !pop) |-> !push)
    else $error("command pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("command popped from empty queue");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last) |=>
      (out_valid && out_data.last &&
       out_data.write_address == tbp_pkg::ADDR_WIDTH'($past(out_data.write_address) + 1'b1)))
    else $error("second write of a pair missing or misaddressed");

endmodule
